### design/wvs_pkg.sv
package wvs_pkg;

  localparam int unsigned VoiceCountDef = 15;
  localparam int unsigned WaveSizeDef   = 1024;
  localparam int unsigned KeyCount      = 128;
  localparam int unsigned KeyW          = 7;
  localparam int unsigned StepW         = 32;
  localparam int unsigned PhaseW        = 32;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_NOTE_ON = 3'd1,
    OP_NOTE_OFF = 3'd2,
    OP_BEND  = 3'd3,
    OP_LOAD_WAVE = 3'd4,
    OP_LOAD_STEP = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WORK,
    ST_MIX,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic         active;
    logic [6:0]   key;
    logic [3:0]   channel;
    logic [6:0]   volume;
    logic [31:0]  step;
    logic [31:0]  phase;
  } voice_t;

  function automatic logic [16:0] bend_mult(input logic [5:0] i);
    logic [16:0] r;
    begin
      case (i)
        6'd0: r = 17'd61858;  6'd1: r = 17'd61970;  6'd2: r = 17'd62081;
        6'd3: r = 17'd62194;  6'd4: r = 17'd62306;  6'd5: r = 17'd62419;
        6'd6: r = 17'd62531;  6'd7: r = 17'd62644;  6'd8: r = 17'd62757;
        6'd9: r = 17'd62871;  6'd10: r = 17'd62984; 6'd11: r = 17'd63098;
        6'd12: r = 17'd63212; 6'd13: r = 17'd63326; 6'd14: r = 17'd63441;
        6'd15: r = 17'd63556; 6'd16: r = 17'd63670; 6'd17: r = 17'd63785;
        6'd18: r = 17'd63901; 6'd19: r = 17'd64016; 6'd20: r = 17'd64132;
        6'd21: r = 17'd64248; 6'd22: r = 17'd64364; 6'd23: r = 17'd64480;
        6'd24: r = 17'd64596; 6'd25: r = 17'd64713; 6'd26: r = 17'd64830;
        6'd27: r = 17'd64947; 6'd28: r = 17'd65065; 6'd29: r = 17'd65182;
        6'd30: r = 17'd65300; 6'd31: r = 17'd65418; 6'd32: r = 17'd65536;
        6'd33: r = 17'd65654; 6'd34: r = 17'd65773; 6'd35: r = 17'd65892;
        6'd36: r = 17'd66011; 6'd37: r = 17'd66130; 6'd38: r = 17'd66250;
        6'd39: r = 17'd66369; 6'd40: r = 17'd66489; 6'd41: r = 17'd66609;
        6'd42: r = 17'd66730; 6'd43: r = 17'd66850; 6'd44: r = 17'd66971;
        6'd45: r = 17'd67092; 6'd46: r = 17'd67213; 6'd47: r = 17'd67335;
        6'd48: r = 17'd67456; 6'd49: r = 17'd67578; 6'd50: r = 17'd67700;
        6'd51: r = 17'd67823; 6'd52: r = 17'd67945; 6'd53: r = 17'd68068;
        6'd54: r = 17'd68191; 6'd55: r = 17'd68314; 6'd56: r = 17'd68438;
        6'd57: r = 17'd68561; 6'd58: r = 17'd68685; 6'd59: r = 17'd68809;
        6'd60: r = 17'd68933; 6'd61: r = 17'd69058; 6'd62: r = 17'd69183;
        default: r = 17'd69308;
      endcase
      return r;
    end
  endfunction

endpackage

### design/wvs_tables.sv
module wvs_tables #(
  parameter int unsigned WaveSize = wvs_pkg::WaveSizeDef,
  localparam int unsigned WaveAw = $clog2(WaveSize)
) (
  input  logic                      clk_i,
  input  logic                      wave_we_i,
  input  logic [WaveAw-1:0]         wave_waddr_i,
  input  logic signed [15:0]        wave_wdata_i,
  input  logic [WaveAw-1:0]         wave_raddr_i,
  output logic signed [15:0]        wave_rdata_o,
  input  logic                      step_we_i,
  input  logic [wvs_pkg::KeyW-1:0]  step_waddr_i,
  input  logic [25:0]               step_wdata_i,
  input  logic [wvs_pkg::KeyW-1:0]  step_raddr_i,
  output logic [25:0]               step_rdata_o
);
  import wvs_pkg::*;

  logic signed [15:0] wave_mem [WaveSize];
  logic [25:0]        step_mem [KeyCount];

  always_ff @(posedge clk_i) begin
    if (wave_we_i) begin
      wave_mem[wave_waddr_i] <= wave_wdata_i;
    end
    wave_rdata_o <= wave_mem[wave_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (step_we_i) begin
      step_mem[step_waddr_i] <= step_wdata_i;
    end
    step_rdata_o <= step_mem[step_raddr_i];
  end

endmodule

### design/wavetable_voice_synth.sv
// Channel   Ports                                          Direction
// request   start_i, busy_o, operation_i .. step_value_i   in
// result    dac_valid_o, dac_sample_o                      out
//
// Voices are walked one per pass, in three steps each (read, update, write).
// A tick or bend holds busy_o over all voices and ST_DONE; only a tick strobes a
// sample, in the cycle after ST_DONE; note on/off stop one voice pass after the match.
// Table loads and unknown codes finish in the accept cycle; busy_o stays low.
// Voice state sits in a synchronous RAM whose valid bits are cleared by rst_ni.
// The receiver cannot stall: the result strobe lasts exactly one cycle.
module wavetable_voice_synth #(
  parameter int unsigned VoiceCount = wvs_pkg::VoiceCountDef,
  parameter int unsigned WaveSize   = wvs_pkg::WaveSizeDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  output logic         busy_o,
  input  logic [2:0]   operation_i,
  input  logic [3:0]   channel_i,
  input  logic [6:0]   key_i,
  input  logic [6:0]   velocity_i,
  input  logic [13:0]  bend_i,
  input  logic [9:0]   table_index_i,
  input  logic signed [15:0] wave_sample_i,
  input  logic [25:0]  step_value_i,
  output logic         dac_valid_o,
  output logic [11:0]  dac_sample_o
);
  import wvs_pkg::*;

  localparam int unsigned WaveAw = $clog2(WaveSize);
  localparam int unsigned VIdxW  = (VoiceCount > 1) ? $clog2(VoiceCount) : 1;
  localparam logic [PhaseW-1:0] Limit = PhaseW'(WaveSize) << 16;

  state_e state_q, state_d;
  logic [2:0] op_q;
  logic [3:0] chan_q;
  logic [6:0] key_q, velo_q;
  logic [5:0] bidx_q;
  logic [VIdxW-1:0] v_q;
  logic done_q;
  logic signed [31:0] acc_q;
  logic [11:0] dac_q;
  logic dvalid_q;

  voice_t voice_mem [VoiceCount];
  logic [VoiceCount-1:0] valid_q;
  voice_t voice_rd_q;
  logic voice_vld_q;
  logic [VIdxW-1:0] rd_addr;
  voice_t cur_q, cur_d, rd_v;
  logic signed [31:0] acc_d;
  logic wr_en;

  logic wave_we, step_we;
  logic signed [15:0] wave_rd;
  logic [25:0] step_rd;
  logic [WaveAw-1:0] wave_ra;
  logic [KeyW-1:0] step_ra;
  logic [PhaseW-1:0] ph_sum;
  logic [PhaseW-1:0] ph_new;
  logic signed [23:0] prod;
  logic [42:0] bprod;
  logic signed [31:0] mix;

  assign wave_we = start_i && !busy_o && operation_i == OP_LOAD_WAVE
                   && {22'd0, table_index_i} < WaveSize;
  assign step_we = start_i && !busy_o && operation_i == OP_LOAD_STEP
                   && {22'd0, table_index_i} < KeyCount;

  assign ph_sum = cur_q.phase + cur_q.step;
  assign ph_new = (ph_sum >= Limit) ? ph_sum - Limit : ph_sum;
  assign wave_ra = ph_new[16 +: WaveAw];
  assign step_ra = (op_q == OP_BEND) ? rd_v.key : key_q;

  wvs_tables #(.WaveSize(WaveSize)) u_tables (
    .clk_i,
    .wave_we_i   (wave_we),
    .wave_waddr_i(WaveAw'(table_index_i)),
    .wave_wdata_i(wave_sample_i),
    .wave_raddr_i(wave_ra),
    .wave_rdata_o(wave_rd),
    .step_we_i   (step_we),
    .step_waddr_i(table_index_i[KeyW-1:0]),
    .step_wdata_i(step_value_i),
    .step_raddr_i(step_ra),
    .step_rdata_o(step_rd)
  );

  // fetch the next voice while the current one is written back
  always_comb begin
    rd_addr = v_q;
    if (state_q == ST_IDLE) begin
      rd_addr = '0;
    end else if (state_q == ST_MIX && v_q != VIdxW'(VoiceCount - 1)) begin
      rd_addr = v_q + 1'b1;
    end
  end

  always_comb begin
    rd_v = '0;
    if (voice_vld_q) begin
      rd_v = voice_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      voice_vld_q <= 1'b0;
    end else begin
      voice_vld_q <= valid_q[rd_addr];
      if (wr_en) begin
        valid_q[v_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      voice_mem[v_q] <= cur_d;
    end
    voice_rd_q <= voice_mem[rd_addr];
  end

  assign prod  = 24'(wave_rd) * $signed({17'd0, cur_q.volume});
  assign bprod = 43'(step_rd) * 43'(bend_mult(bidx_q));
  assign mix   = (acc_q >>> 10) + 32'sd2048;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) begin
        if (operation_i == OP_TICK || operation_i == OP_NOTE_ON ||
            operation_i == OP_NOTE_OFF || operation_i == OP_BEND) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_WORK;
      ST_WORK: state_d = ST_MIX;
      ST_MIX:  state_d = (done_q || v_q == VIdxW'(VoiceCount - 1)) ? ST_DONE : ST_READ;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cur_d = cur_q;
    acc_d = acc_q;
    wr_en = 1'b0;
    if (state_q == ST_WORK && !done_q) begin
      case (op_q)
        OP_TICK: if (cur_q.active) begin
          cur_d.phase = ph_new;
        end
        default: ;
      endcase
    end else if (state_q == ST_MIX && !done_q) begin
      wr_en = 1'b1;
      case (op_q)
        OP_TICK: if (cur_q.active) begin
          acc_d = acc_q + 32'(prod >>> 4);
        end
        OP_NOTE_ON: if (!cur_q.active) begin
          cur_d.active = 1'b1;
          cur_d.key = key_q;
          cur_d.channel = chan_q;
          cur_d.volume = velo_q;
          cur_d.phase = '0;
          cur_d.step = {6'd0, step_rd};
        end
        OP_NOTE_OFF: if (cur_q.active && cur_q.key == key_q) begin
          cur_d.active = 1'b0;
          cur_d.channel = '0;
          cur_d.step = {6'd0, step_rd};
        end
        OP_BEND: if (cur_q.active && cur_q.channel == chan_q) begin
          cur_d.step = {5'd0, bprod[42:16]};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      v_q      <= '0;
      done_q   <= 1'b0;
      acc_q    <= '0;
      dvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      dvalid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          v_q <= '0;
          done_q <= 1'b0;
          acc_q <= '0;
        end
        ST_MIX: begin
          acc_q <= acc_d;
          if ((op_q == OP_NOTE_ON && !cur_q.active) ||
              (op_q == OP_NOTE_OFF && cur_q.active && cur_q.key == key_q)) begin
            done_q <= 1'b1;
          end
          v_q <= v_q + 1'b1;
        end
        ST_DONE: dvalid_q <= (op_q == OP_TICK);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      op_q   <= (operation_i == OP_NOTE_ON && velocity_i == 7'd0) ? OP_NOTE_OFF : operation_i;
      chan_q <= channel_i;
      key_q  <= key_i;
      velo_q <= velocity_i;
      bidx_q <= bend_i[13:8];
    end
    if (state_q == ST_READ) begin
      cur_q <= rd_v;
    end else begin
      cur_q <= cur_d;
    end
    if (state_q == ST_DONE) begin
      if (mix > 32'sd4095) begin
        dac_q <= 12'd4095;
      end else if (mix < 0) begin
        dac_q <= 12'd0;
      end else begin
        dac_q <= mix[11:0];
      end
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign dac_valid_o = dvalid_q;
  assign dac_sample_o = dac_q;

endmodule

### test/tb_wavetable_voice_synth.sv
`timescale 1ns / 1ps

module tb_wavetable_voice_synth;
  import wvs_pkg::*;

  localparam int unsigned NV = VoiceCountDef;
  localparam int unsigned NW = WaveSizeDef;
  localparam logic [2:0] OP_BAD6 = 3'd6;
  localparam logic [2:0] OP_BAD7 = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [3:0]  chan;
    logic [6:0]  key;
    logic [6:0]  vel;
    logic [13:0] bend;
    logic [9:0]  idx;
    logic [15:0] ws;
    logic [25:0] sv;
    int          gap;
    bit          sync;
  } req_t;

  logic clk_i, rst_ni, start_i, busy_o, dac_valid_o;
  logic [2:0] operation_i;
  logic [3:0] channel_i;
  logic [6:0] key_i, velocity_i;
  logic [13:0] bend_i;
  logic [9:0] table_index_i;
  logic signed [15:0] wave_sample_i;
  logic [25:0] step_value_i;
  logic [11:0] dac_sample_o;

  wavetable_voice_synth i_dut (.*);

  req_t        pending_q[$];
  logic [11:0] dac_expected_q[$];
  int          errors = 0;
  int          samples_checked = 0;
  int          requests_taken = 0;
  logic        taken;
  int          cur_gap = 0;

  // synth state mirror
  logic               act_m[NV];
  logic [6:0]         key_m[NV];
  logic [3:0]         chan_m[NV];
  logic [6:0]         vol_m[NV];
  logic [31:0]        stp_m[NV];
  logic [31:0]        ph_m[NV];
  logic signed [15:0] wave_m[NW];
  logic [25:0]        keystep_m[KeyCount];

  logic [16:0] pitch_mul[64] = '{
    61858, 61970, 62081, 62194, 62306, 62419, 62531, 62644,
    62757, 62871, 62984, 63098, 63212, 63326, 63441, 63556,
    63670, 63785, 63901, 64016, 64132, 64248, 64364, 64480,
    64596, 64713, 64830, 64947, 65065, 65182, 65300, 65418,
    65536, 65654, 65773, 65892, 66011, 66130, 66250, 66369,
    66489, 66609, 66730, 66850, 66971, 67092, 67213, 67335,
    67456, 67578, 67700, 67823, 67945, 68068, 68191, 68314,
    68438, 68561, 68685, 68809, 68933, 69058, 69183, 69308};

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic release_voice(input logic [6:0] k);
    for (int v = 0; v < NV; v++) begin
      if (act_m[v] && key_m[v] == k) begin
        act_m[v] = 1'b0;
        chan_m[v] = '0;
        stp_m[v] = 32'(keystep_m[k]);
        return;
      end
    end
  endtask

  task automatic predict_synth(input req_t r);
    longint acc;
    longint prod;
    logic [63:0] t;
    logic [9:0] a;
    bit placed;
    acc = 0;
    placed = 0;
    case (r.op)
      OP_TICK: begin
        for (int v = 0; v < NV; v++) begin
          if (act_m[v]) begin
            ph_m[v] = ph_m[v] + stp_m[v];
            if (ph_m[v] >= (32'(NW) << 16)) ph_m[v] = ph_m[v] - (32'(NW) << 16);
            a = ph_m[v][25:16];
            prod = longint'(wave_m[a]) * longint'(vol_m[v]);
            acc += prod >>> 4;
          end
        end
        acc = (acc >>> 10) + 2048;
        if (acc > 4095) acc = 4095;
        else if (acc < 0) acc = 0;
        dac_expected_q.push_back(12'(acc));
      end
      OP_NOTE_ON: begin
        if (r.vel == 0) release_voice(r.key);
        else begin
          for (int v = 0; v < NV; v++) begin
            if (!act_m[v] && !placed) begin
              placed = 1;
              key_m[v] = r.key;
              stp_m[v] = 32'(keystep_m[r.key]);
              ph_m[v] = '0;
              vol_m[v] = r.vel;
              chan_m[v] = r.chan;
              act_m[v] = 1'b1;
            end
          end
        end
      end
      OP_NOTE_OFF: release_voice(r.key);
      OP_BEND: begin
        for (int v = 0; v < NV; v++) begin
          if (act_m[v] && chan_m[v] == r.chan) begin
            t = 64'(keystep_m[key_m[v]]) * 64'(pitch_mul[r.bend[13:8]]);
            stp_m[v] = t[47:16];
          end
        end
      end
      OP_LOAD_WAVE: if (r.idx < NW) wave_m[r.idx] = r.ws;
      OP_LOAD_STEP: if (r.idx < KeyCount) keystep_m[r.idx] = r.sv;
      default: ;
    endcase
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver
  always @(negedge clk_i) begin
    if (!start_i || taken) begin
      if (pending_q.size() > 0 && rst_ni &&
          !(pending_q[0].sync && dac_expected_q.size() > 0) &&
          !($urandom_range(99) < pending_q[0].gap)) begin
        operation_i   <= pending_q[0].op;
        channel_i     <= pending_q[0].chan;
        key_i         <= pending_q[0].key;
        velocity_i    <= pending_q[0].vel;
        bend_i        <= pending_q[0].bend;
        table_index_i <= pending_q[0].idx;
        wave_sample_i <= pending_q[0].ws;
        step_value_i  <= pending_q[0].sv;
        void'(pending_q.pop_front());
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    req_t r;
    taken <= start_i && !busy_o;
    if (rst_ni && start_i && !busy_o) begin
      r.op = operation_i; r.chan = channel_i; r.key = key_i; r.vel = velocity_i;
      r.bend = bend_i; r.idx = table_index_i; r.ws = wave_sample_i;
      r.sv = step_value_i;
      predict_synth(r);
      requests_taken++;
    end
    if (rst_ni && dac_valid_o) begin
      if (dac_expected_q.size() == 0) report("dac sample with none expected");
      else begin
        if (dac_sample_o !== dac_expected_q[0])
          report($sformatf("dac_sample got %0d exp %0d", dac_sample_o, dac_expected_q[0]));
        void'(dac_expected_q.pop_front());
        samples_checked++;
      end
    end
  end

  function automatic req_t rnd_req(input logic [2:0] op, input int gap);
    req_t r;
    r.op = op; r.chan = 4'($urandom); r.key = 7'($urandom); r.vel = 7'($urandom);
    r.bend = 14'($urandom); r.idx = 10'($urandom); r.ws = 16'($urandom);
    r.sv = 26'($urandom); r.gap = gap; r.sync = 0;
    return r;
  endfunction

  task automatic add(input req_t r);
    pending_q.push_back(r);
  endtask

  initial begin
    req_t r;
    logic [6:0] pool[8];
    int gaps[4] = '{0, 83, 0, 22};
    int p;
    int limit;
    start_i = 0; operation_i = OP_TICK; channel_i = 0; key_i = 0; velocity_i = 0;
    bend_i = 0; table_index_i = 0; wave_sample_i = 0; step_value_i = 0; taken = 0;
    rst_ni = 1'b0;
    for (int v = 0; v < NV; v++) begin
      act_m[v] = 0; key_m[v] = 0; chan_m[v] = 0; vol_m[v] = 0; stp_m[v] = 0; ph_m[v] = 0;
    end
    // preload both tables so no unwritten entry is ever read
    for (int i = 0; i < NW; i++) begin
      r = rnd_req(OP_LOAD_WAVE, 0); r.idx = 10'(i); add(r);
    end
    for (int i = 0; i < KeyCount; i++) begin
      r = rnd_req(OP_LOAD_STEP, 0); r.idx = 10'(i); r.sv = 26'($urandom_range(0, 2000000));
      add(r);
    end
    // directed: saturation, voice pool full, extremes
    r = rnd_req(OP_LOAD_STEP, 0); r.idx = 0; r.sv = 0; add(r);
    r = rnd_req(OP_LOAD_WAVE, 0); r.idx = 0; r.ws = 16'h7fff; add(r);
    r = rnd_req(OP_LOAD_STEP, 0); r.idx = 10'd200; add(r);
    for (int i = 0; i < 16; i++) begin
      r = rnd_req(OP_NOTE_ON, 0); r.key = 0; r.vel = 7'd127; add(r);
    end
    add(rnd_req(OP_TICK, 0));
    r = rnd_req(OP_LOAD_WAVE, 0); r.idx = 0; r.ws = 16'h8000; add(r);
    add(rnd_req(OP_TICK, 0));
    r = rnd_req(OP_BEND, 0); r.bend = 14'h3fff; add(r);
    r = rnd_req(OP_BEND, 0); r.bend = 0; add(r);
    for (int i = 0; i < 15; i++) begin
      r = rnd_req(OP_NOTE_OFF, 0); r.key = 0; add(r);
    end
    r = rnd_req(OP_NOTE_OFF, 0); r.key = 0; add(r);
    r = rnd_req(OP_LOAD_STEP, 0); r.idx = 10'd127; r.sv = 26'h3ffffff; add(r);
    r = rnd_req(OP_LOAD_WAVE, 0); r.idx = 10'd1023; r.ws = 16'h7fff; add(r);
    r = rnd_req(OP_NOTE_ON, 0); r.key = 7'd127; r.vel = 7'd1; r.chan = 4'hf; add(r);
    for (int i = 0; i < 4; i++) add(rnd_req(OP_TICK, 0));
    add(rnd_req(OP_BAD6, 0));
    add(rnd_req(OP_BAD7, 0));
    r = rnd_req(OP_NOTE_ON, 0); r.key = 7'd127; r.vel = 0; add(r);
    add(rnd_req(OP_TICK, 0));
    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      for (int i = 0; i < 8; i++) pool[i] = 7'($urandom);
      for (int i = 0; i < 265; i++) begin
        p = $urandom_range(99);
        if (p < 40) r = rnd_req(OP_TICK, gaps[ph]);
        else if (p < 62) begin
          r = rnd_req(OP_NOTE_ON, gaps[ph]);
          if (r.vel == 0) r.vel = 7'd1;
          if ($urandom_range(3) != 0) r.key = pool[$urandom_range(7)];
        end else if (p < 76) begin
          r = rnd_req(OP_NOTE_OFF, gaps[ph]);
          if ($urandom_range(3) != 0) r.key = pool[$urandom_range(7)];
        end else if (p < 79) begin
          r = rnd_req(OP_NOTE_ON, gaps[ph]); r.vel = 0; r.key = pool[$urandom_range(7)];
        end else if (p < 89) r = rnd_req(OP_BEND, gaps[ph]);
        else if (p < 93) r = rnd_req(OP_LOAD_WAVE, gaps[ph]);
        else if (p < 97) begin
          r = rnd_req(OP_LOAD_STEP, gaps[ph]); r.idx = 10'($urandom_range(0, 255));
        end else r = rnd_req($urandom_range(1) ? OP_BAD6 : OP_BAD7, gaps[ph]);
        r.sync = (i == 0);
        add(r);
      end
    end
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    wait (pending_q.size() == 0);
    @(posedge clk_i);
    while (start_i) @(posedge clk_i);
    limit = 0;
    while (dac_expected_q.size() > 0 && limit < 10000) begin
      @(posedge clk_i);
      limit++;
    end
    if (dac_expected_q.size() > 0) report("dac samples still outstanding");
    repeat (100) @(posedge clk_i);
    $display("%0d requests accepted, %0d dac samples checked over four idle phases",
             requests_taken, samples_checked);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
design/wvs_pkg.sv
design/wvs_tables.sv
design/wavetable_voice_synth.sv
test/tb_wavetable_voice_synth.sv
